>>> src/conv2d_clamped_8bit_top_macros.svh
// ----------------------------------------------------------------------------
// conv2d_clamped_8bit_top_macros: assertion helpers
// Checks on aclk, switched off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef CONV2D_CLAMPED_8BIT_TOP_MACROS_SVH
`define CONV2D_CLAMPED_8BIT_TOP_MACROS_SVH

// same-cycle implication
`define C2D_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define C2D_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/c2d_pkg.sv
// ----------------------------------------------------------------------------
// c2d_pkg: shared types and constants of the 3x3 image convolution
// Field widths, register indexes, reset values and coefficient extraction.
// ----------------------------------------------------------------------------
`default_nettype none

package c2d_pkg;

    localparam int KDIM           = 3;
    localparam int PIX_W          = 8;
    localparam int COEF_W         = 16;
    localparam int COEF_FRAC_BITS = 8;
    localparam int KROW_W         = KDIM * COEF_W;
    localparam int POS_W          = 10;
    localparam int SIZE_CFG_W     = 11;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 48;
    localparam int PROD_W         = COEF_W + PIX_W + 1;
    localparam int SUM_W          = PROD_W + 4;

    localparam logic [CFG_IDX_W-1:0] CFG_KROW_TOP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW_BOT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDING  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd5;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [KROW_W-1:0] KROW_TOP_RST = 48'h0000_0000_0000;
    localparam logic [KROW_W-1:0] KROW_MID_RST = 48'h0000_0001_0000;
    localparam logic [KROW_W-1:0] KROW_BOT_RST = 48'h0000_0000_0000;

    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic [KROW_W-1:0]        krow_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic [KDIM-1:0] row_ok;
        logic [KDIM-1:0] col_ok;
    } c2d_mask_t;

    typedef struct packed {
        logic             produce;
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        c2d_mask_t        mask;
    } c2d_ctl_t;

    function automatic logic signed [COEF_W-1:0] coef_at(input krow_t row, input int unsigned c);
        return $signed(row[COEF_W*c +: COEF_W]);
    endfunction

endpackage

`default_nettype wire

>>> src/c2d_ram.sv
// ----------------------------------------------------------------------------
// c2d_ram: simple dual-port RAM
// One write port, one read port with registered read data (old data on a
// same-address write).
// ----------------------------------------------------------------------------
`default_nettype none

module c2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/c2d_mac.sv
// ----------------------------------------------------------------------------
// c2d_mac: 3x3 window, tap products and sum
// Shifts a new column into the window, registers the masked products of the
// flipped kernel, then the row sums; the total is given combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module c2d_mac import c2d_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      shift_en,
    input  logic      sum_en,
    input  pix_t      top_px,
    input  pix_t      mid_px,
    input  pix_t      bot_px,
    input  c2d_mask_t mask,
    input  krow_t     kernel [KDIM],
    output sum_t      sum
);

    pix_t  win_reg   [KDIM][KDIM];
    pix_t  win_next  [KDIM][KDIM];
    pix_t  new_col   [KDIM];
    prod_t prod_reg  [KDIM][KDIM];
    prod_t prod_next [KDIM][KDIM];
    sum_t  rsum_reg  [KDIM];
    sum_t  rsum_next [KDIM];

    assign new_col[0] = top_px;
    assign new_col[1] = mid_px;
    assign new_col[2] = bot_px;

    always_comb begin
        for (int a = 0; a < KDIM; a++) begin
            for (int j = 0; j < KDIM - 1; j++) begin
                win_next[a][j] = win_reg[a][j+1];
            end
            win_next[a][KDIM-1] = new_col[a];
        end
    end

    always_comb begin
        pix_t tap;
        for (int k = 0; k < KDIM; k++) begin
            for (int l = 0; l < KDIM; l++) begin
                tap = (mask.row_ok[k] && mask.col_ok[l]) ? win_next[k][l] : '0;
                prod_next[k][l] = coef_at(kernel[KDIM-1-k], KDIM - 1 - l) * $signed({1'b0, tap});
            end
        end
    end

    always_comb begin
        for (int k = 0; k < KDIM; k++) begin
            rsum_next[k] = '0;
            for (int l = 0; l < KDIM; l++) begin
                rsum_next[k] = rsum_next[k] + SUM_W'(prod_reg[k][l]);
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < KDIM; k++) begin
            sum = sum + rsum_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < KDIM; a++) begin
                for (int j = 0; j < KDIM; j++) begin
                    win_reg[a][j] <= '0;
                end
            end
        end else if (shift_en) begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            prod_reg <= prod_next;
        end
        if (sum_en) begin
            rsum_reg <= rsum_next;
        end
    end

endmodule

`default_nettype wire

>>> src/conv2d_clamped_8bit_top.sv
// ----------------------------------------------------------------------------
// conv2d_clamped_8bit_top: streaming 3x3 convolution of an 8-bit grey image
// Raster pixels in, clamped convolution results with their positions out.
//
//  channel | ports                                       | dir | moves
//  --------+---------------------------------------------+-----+-------------------
//  s_      | s_valid s_ready s_operation s_pixel_in      | in  | pixel or drain
//  m_      | m_valid m_ready m_pixel_out m_out_row       | out | one result pixel
//          | m_out_col m_was_clamped m_last_of_image     |     |
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data      | in  | register write
//
// One request per cycle sustained while m_ready does not hold results back;
// the line buffer RAM is read and written once per pixel and the window then
// advances one column per cycle. A result passes through the stage and m_
// registers. Reset clears counters, window and registers; the line buffer
// needs no clearing pass. Each stage holds on a stall and empty stages fill up,
// so requests keep coming in while a result waits. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "conv2d_clamped_8bit_top_macros.svh"

module conv2d_clamped_8bit_top import c2d_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_operation,
    input  logic [PIX_W-1:0]      s_pixel_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_pixel_out,
    output logic [POS_W-1:0]      m_out_row,
    output logic [POS_W-1:0]      m_out_col,
    output logic                  m_was_clamped,
    output logic                  m_last_of_image,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
    localparam sum_t TOP_Q = sum_t'(255 * (1 << COEF_FRAC_BITS));

    // configuration
    krow_t           kernel_reg [KDIM];
    logic            pad_reg;
    logic [WW-1:0]   w_reg;
    logic [HW-1:0]   h_reg;
    logic [SIZE_CFG_W-1:0] size_cfg;
    logic [WW-1:0]   w_cfg;
    logic [HW-1:0]   h_cfg;
    logic            cfg_fire;

    // stage 1 and counters
    logic            v1_reg;
    logic            op1_reg;
    pix_t            px1_reg;
    logic [CW-1:0]   col_reg;
    logic [RW-1:0]   row_reg;
    logic [CW-1:0]   col_c;
    logic [RW-1:0]   row_c;
    logic [RW-1:0]   orow;
    logic [CW-1:0]   ocol;
    logic [RW-1:0]   rrow_full;
    logic [CW-1:0]   rcol_full;
    logic [RW+POS_W-1:0] rrow_x;
    logic [CW+POS_W-1:0] rcol_x;
    logic            clr;
    logic            active;
    logic            ignore;
    logic            col_end;
    logic            pre;
    logic            beyond;
    logic            fin;
    logic            r_ok0;
    logic            r_ok2;
    logic            c_ok0;
    logic            c_ok2;
    logic            inner;
    logic            last_v;
    pix_t            bot1;
    c2d_ctl_t        ctl1;

    // stage 2
    logic            v2_reg;
    c2d_ctl_t        ctl2_reg;
    logic [CW-1:0]   x2_reg;
    pix_t            bot2_reg;
    logic            byp_reg;
    logic [2*PIX_W-1:0] byp_data_reg;
    logic [2*PIX_W-1:0] rd_data;
    pix_t            top2;
    pix_t            mid2;

    // stages 3, 4 and output
    logic            v3_reg;
    logic            v4_reg;
    c2d_ctl_t        ctl3_reg;
    c2d_ctl_t        ctl4_reg;
    sum_t            sum;
    logic            m_valid_reg;
    pix_t            m_pixel_out_reg;
    logic [POS_W-1:0] m_out_row_reg;
    logic [POS_W-1:0] m_out_col_reg;
    logic            m_was_clamped_reg;
    logic            m_last_reg;
    pix_t            pix_val;
    logic            clamped;

    // handshake
    logic            adv4;
    logic            adv3;
    logic            adv2;
    logic            take1;
    logic            load2;
    logic            s_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign size_cfg  = cfg_data[SIZE_CFG_W-1:0];

    always_comb begin
        if (size_cfg == '0) begin
            w_cfg = WW'(1);
            h_cfg = HW'(1);
        end else begin
            w_cfg = (size_cfg > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(size_cfg);
            h_cfg = (size_cfg > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(size_cfg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg[0] <= KROW_TOP_RST;
            kernel_reg[1] <= KROW_MID_RST;
            kernel_reg[2] <= KROW_BOT_RST;
            pad_reg       <= 1'b1;
            w_reg         <= WW'(W_RST);
            h_reg         <= HW'(H_RST);
        end else if (cfg_fire) begin
            unique case (cfg_index)
                CFG_KROW_TOP: kernel_reg[0] <= cfg_data[KROW_W-1:0];
                CFG_KROW_MID: kernel_reg[1] <= cfg_data[KROW_W-1:0];
                CFG_KROW_BOT: kernel_reg[2] <= cfg_data[KROW_W-1:0];
                CFG_PADDING:  pad_reg       <= cfg_data[0];
                CFG_WIDTH:    w_reg         <= w_cfg;
                CFG_HEIGHT:   h_reg         <= h_cfg;
                default: begin
                end
            endcase
        end
    end

    // handshake chain, back to front
    assign adv4   = v4_reg && (!ctl4_reg.produce || !m_valid_reg || m_ready);
    assign adv3   = v3_reg && (!v4_reg || adv4);
    assign adv2   = v2_reg && (!v3_reg || adv3);
    assign take1  = v1_reg && (ignore || !v2_reg || adv2);
    assign load2  = take1 && !ignore;
    assign s_ready = !v1_reg || take1;
    assign s_fire = s_valid && s_ready;

    // stage 1: position bookkeeping
    always_comb begin
        clr     = (WW'(col_reg) >= w_reg) || (row_reg > RW'(h_reg) + RW'(1));
        col_c   = clr ? '0 : col_reg;
        row_c   = clr ? '0 : row_reg;
        active  = row_c < RW'(h_reg);
        ignore  = active && (op1_reg == OP_DRAIN);
        bot1    = active ? px1_reg : '0;
        col_end = WW'(col_c) == w_reg - WW'(1);
        pre     = (row_c == '0) || ((row_c == RW'(1)) && (col_c == '0));
        orow    = (col_c != '0) ? row_c - RW'(1) : row_c - RW'(2);
        ocol    = (col_c != '0) ? col_c - CW'(1) : CW'(w_reg - WW'(1));
        beyond  = orow >= RW'(h_reg);
        fin     = (orow == RW'(h_reg) - RW'(1)) && (WW'(ocol) == w_reg - WW'(1));
        r_ok0   = orow != '0;
        r_ok2   = orow + RW'(1) < RW'(h_reg);
        c_ok0   = ocol != '0;
        c_ok2   = WW'(ocol) + WW'(1) < w_reg;
        inner   = r_ok0 && r_ok2 && c_ok0 && c_ok2;
        last_v  = inner && (orow == RW'(h_reg) - RW'(2)) && (WW'(ocol) == w_reg - WW'(2));
        rrow_full = pad_reg ? orow : orow - RW'(1);
        rcol_full = pad_reg ? ocol : ocol - CW'(1);
        rrow_x  = {{POS_W{1'b0}}, rrow_full};
        rcol_x  = {{POS_W{1'b0}}, rcol_full};

        ctl1.produce     = !pre && !beyond && (pad_reg || inner);
        ctl1.last        = pad_reg ? fin : last_v;
        ctl1.row         = rrow_x[POS_W-1:0];
        ctl1.col         = rcol_x[POS_W-1:0];
        ctl1.mask.row_ok = {r_ok2, 1'b1, r_ok0};
        ctl1.mask.col_ok = {c_ok2, 1'b1, c_ok0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            if (s_fire) begin
                v1_reg <= 1'b1;
            end else if (take1) begin
                v1_reg <= 1'b0;
            end
            if (take1) begin
                if (ignore) begin
                    col_reg <= col_c;
                    row_reg <= row_c;
                end else if (!pre && (beyond || fin)) begin
                    col_reg <= '0;
                    row_reg <= '0;
                end else if (col_end) begin
                    col_reg <= '0;
                    row_reg <= row_c + RW'(1);
                end else begin
                    col_reg <= col_c + CW'(1);
                    row_reg <= row_c;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op1_reg <= s_operation;
            px1_reg <= s_pixel_in;
        end
    end

    // line buffer: [7:0] upper row, [15:8] middle row
    c2d_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (adv2),
        .wr_addr (x2_reg),
        .wr_data ({bot2_reg, mid2}),
        .rd_en   (load2),
        .rd_addr (col_c),
        .rd_data (rd_data)
    );

    // take the word being written in the same cycle as the read
    assign top2 = byp_reg ? byp_data_reg[PIX_W-1:0]       : rd_data[PIX_W-1:0];
    assign mid2 = byp_reg ? byp_data_reg[2*PIX_W-1:PIX_W] : rd_data[2*PIX_W-1:PIX_W];

    always_ff @(posedge aclk) begin
        if (load2) begin
            ctl2_reg     <= ctl1;
            x2_reg       <= col_c;
            bot2_reg     <= bot1;
            byp_reg      <= adv2 && (x2_reg == col_c);
            byp_data_reg <= {bot2_reg, mid2};
        end
        if (adv2) begin
            ctl3_reg <= ctl2_reg;
        end
        if (adv3) begin
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (load2) begin
                v2_reg <= 1'b1;
            end else if (adv2) begin
                v2_reg <= 1'b0;
            end
            if (adv2) begin
                v3_reg <= 1'b1;
            end else if (adv3) begin
                v3_reg <= 1'b0;
            end
            if (adv3) begin
                v4_reg <= 1'b1;
            end else if (adv4) begin
                v4_reg <= 1'b0;
            end
        end
    end

    c2d_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (adv2),
        .sum_en   (adv3),
        .top_px   (top2),
        .mid_px   (mid2),
        .bot_px   (bot2_reg),
        .mask     (ctl2_reg.mask),
        .kernel   (kernel_reg),
        .sum      (sum)
    );

    // clamp and truncate
    always_comb begin
        if (sum[SUM_W-1]) begin
            pix_val = '0;
            clamped = 1'b1;
        end else if (sum > TOP_Q) begin
            pix_val = '1;
            clamped = 1'b1;
        end else begin
            pix_val = sum[COEF_FRAC_BITS +: PIX_W];
            clamped = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv4 && ctl4_reg.produce) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv4 && ctl4_reg.produce) begin
            m_pixel_out_reg   <= pix_val;
            m_out_row_reg     <= ctl4_reg.row;
            m_out_col_reg     <= ctl4_reg.col;
            m_was_clamped_reg <= clamped;
            m_last_reg        <= ctl4_reg.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_out     = m_pixel_out_reg;
    assign m_out_row       = m_out_row_reg;
    assign m_out_col       = m_out_col_reg;
    assign m_was_clamped   = m_was_clamped_reg;
    assign m_last_of_image = m_last_reg;

    `C2D_CHECK_NOW(a_no_overwrite, m_valid_reg && !m_ready, !(adv4 && ctl4_reg.produce), "result overwritten while waiting")
    `C2D_CHECK_NEXT(a_end_restart, take1 && !ignore && !pre && fin, (row_reg == '0) && (col_reg == '0), "counters not restarted after final position")
    `C2D_CHECK_NEXT(a_byp_pair, load2 && !adv2, !byp_reg, "line buffer bypass without a same-cycle write")
    `C2D_CHECK_NEXT(a_out_load, adv4 && ctl4_reg.produce, m_valid_reg, "produced result not presented")

endmodule

`default_nettype wire

>>> tb/conv2d_result_checker.sv
// ----------------------------------------------------------------------------
// conv2d_result_checker: result checker for the streaming 3x3 convolution
// Follows register writes and accepted requests, keeps its own line rows,
// window and raster counters, predicts every result pixel with its position
// and flags, and compares each result the block sends in order, field by field.
// ----------------------------------------------------------------------------
module conv2d_result_checker import c2d_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_operation,
    input  logic [PIX_W-1:0]      s_pixel_in,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [PIX_W-1:0]      m_pixel_out,
    input  logic [POS_W-1:0]      m_out_row,
    input  logic [POS_W-1:0]      m_out_col,
    input  logic                  m_was_clamped,
    input  logic                  m_last_of_image,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           mismatch_count,
    output int unsigned           results_owed
);

    typedef struct {
        pix_t             value;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             clamped;
        logic             last;
    } conv_result_t;

    localparam int CLAMP_TOP = 255 << COEF_FRAC_BITS;

    krow_t                 kern_top;
    krow_t                 kern_mid;
    krow_t                 kern_bot;
    logic                  pad_mode;
    logic [SIZE_CFG_W-1:0] width_reg;
    logic [SIZE_CFG_W-1:0] height_reg;
    pix_t                  row_store [2][MAX_WIDTH];
    pix_t                  window [3][3];
    int unsigned           in_row;
    int unsigned           in_col;
    conv_result_t          expected_pixels [$];
    int unsigned           errors;

    function automatic int unsigned eff_dim(input logic [SIZE_CFG_W-1:0] v,
                                            input int unsigned limit);
        if (v == 0) return 1;
        return (v > limit) ? limit : v;
    endfunction

    function automatic int tap_coef(input int unsigned r, input int unsigned c);
        krow_t                    kr;
        logic signed [COEF_W-1:0] cv;
        kr = (r == 0) ? kern_top : ((r == 1) ? kern_mid : kern_bot);
        cv = kr[COEF_W*c +: COEF_W];
        return int'(cv);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    task automatic convolve_step(input logic op, input pix_t pix);
        int unsigned  w, h, lin, q, orow, ocol, a, k, l;
        int           sum;
        pix_t         bot;
        logic         emit, fin;
        conv_result_t res;
        w = eff_dim(width_reg, MAX_WIDTH);
        h = eff_dim(height_reg, MAX_HEIGHT);
        if (in_col >= w || in_row > h + 1) begin
            in_row = 0;
            in_col = 0;
        end
        bot = '0;
        if (in_row < h) begin
            if (op == OP_DRAIN) return;
            bot = pix;
        end
        for (a = 0; a < 3; a++) begin
            window[a][0] = window[a][1];
            window[a][1] = window[a][2];
        end
        window[0][2] = row_store[0][in_col];
        window[1][2] = row_store[1][in_col];
        window[2][2] = bot;
        row_store[0][in_col] = row_store[1][in_col];
        row_store[1][in_col] = bot;
        lin = in_row * w + in_col;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (lin < w + 1) return;
        q    = lin - (w + 1);
        orow = q / w;
        ocol = q % w;
        if (orow >= h) begin
            in_row = 0;
            in_col = 0;
            return;
        end
        fin = (orow == h - 1) && (ocol == w - 1);
        sum = 0;
        for (k = 0; k < 3; k++) begin
            for (l = 0; l < 3; l++) begin
                if (orow + k >= 1 && orow + k <= h && ocol + l >= 1 && ocol + l <= w)
                    sum += tap_coef(2 - k, 2 - l) * int'(window[k][l]);
            end
        end
        if (sum < 0) begin
            res.value   = '0;
            res.clamped = 1'b1;
        end else if (sum > CLAMP_TOP) begin
            res.value   = 8'hFF;
            res.clamped = 1'b1;
        end else begin
            res.value   = pix_t'(sum >> COEF_FRAC_BITS);
            res.clamped = 1'b0;
        end
        emit     = 1'b1;
        res.last = fin;
        res.row  = POS_W'(orow);
        res.col  = POS_W'(ocol);
        if (!pad_mode) begin
            emit     = orow >= 1 && orow + 1 < h && ocol >= 1 && ocol + 1 < w;
            res.last = emit && orow + 2 == h && ocol + 2 == w;
            res.row  = POS_W'(orow - 1);
            res.col  = POS_W'(ocol - 1);
        end
        if (fin) begin
            in_row = 0;
            in_col = 0;
        end
        if (emit) expected_pixels.push_back(res);
    endtask

    always @(posedge aclk) begin : monitor
        conv_result_t want;
        if (!aresetn) begin
            kern_top   = KROW_TOP_RST;
            kern_mid   = KROW_MID_RST;
            kern_bot   = KROW_BOT_RST;
            pad_mode   = 1'b1;
            width_reg  = SIZE_CFG_W'(MAX_WIDTH);
            height_reg = SIZE_CFG_W'(MAX_HEIGHT);
            for (int i = 0; i < MAX_WIDTH; i++) begin
                row_store[0][i] = '0;
                row_store[1][i] = '0;
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) window[i][j] = '0;
            end
            in_row = 0;
            in_col = 0;
            expected_pixels.delete();
            errors = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_KROW_TOP: kern_top   = cfg_data[KROW_W-1:0];
                    CFG_KROW_MID: kern_mid   = cfg_data[KROW_W-1:0];
                    CFG_KROW_BOT: kern_bot   = cfg_data[KROW_W-1:0];
                    CFG_PADDING:  pad_mode   = cfg_data[0];
                    CFG_WIDTH:    width_reg  = cfg_data[SIZE_CFG_W-1:0];
                    CFG_HEIGHT:   height_reg = cfg_data[SIZE_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) convolve_step(s_operation, s_pixel_in);
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result at row %0d col %0d with no request pending",
                           m_out_row, m_out_col);
                    errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_out", want.value, m_pixel_out);
                    check_field("out_row", want.row, m_out_row);
                    check_field("out_col", want.col, m_out_col);
                    check_field("was_clamped", want.clamped, m_was_clamped);
                    check_field("last_of_image", want.last, m_last_of_image);
                end
            end
        end
        mismatch_count <= errors;
        results_owed   <= expected_pixels.size();
    end

endmodule

>>> tb/conv2d_clamped_8bit_top_tb.sv
// ----------------------------------------------------------------------------
// conv2d_clamped_8bit_top_tb: testbench for the streaming 3x3 convolution
// Streams small images with directed and random kernels, sizes and padding
// modes, drain ticks and stray requests, under random sender and receiver
// idling and one long receiver hold-off; the checker predicts and compares.
// ----------------------------------------------------------------------------
module conv2d_clamped_8bit_top_tb;
    import c2d_pkg::*;

    localparam int RUN_LIMIT = 400000;
    localparam int DIM_MAX   = 1024;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef enum {K_MILD, K_SIGNED, K_RAW, K_EXTREME} kstyle_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_operation = OP_PIXEL;
    logic [PIX_W-1:0]      s_pixel_in  = '0;
    logic                  m_ready     = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = CFG_KROW_TOP;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  s_ready;
    logic                  m_valid;
    logic [PIX_W-1:0]      m_pixel_out;
    logic [POS_W-1:0]      m_out_row;
    logic [POS_W-1:0]      m_out_col;
    logic                  m_was_clamped;
    logic                  m_last_of_image;
    logic                  cfg_ready;

    int unsigned mismatch_count;
    int unsigned results_owed;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    logic        rx_hold_req = 1'b0;
    int unsigned img_w       = DIM_MAX;
    int unsigned img_h       = DIM_MAX;
    int unsigned pixels_sent = 0;
    int unsigned cycles      = 0;

    conv2d_clamped_8bit_top #(
        .MAX_WIDTH  (DIM_MAX),
        .MAX_HEIGHT (DIM_MAX)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_pixel_in      (s_pixel_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_out     (m_pixel_out),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_was_clamped   (m_was_clamped),
        .m_last_of_image (m_last_of_image),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    conv2d_result_checker #(
        .MAX_WIDTH  (DIM_MAX),
        .MAX_HEIGHT (DIM_MAX)
    ) u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_pixel_in      (s_pixel_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_out     (m_pixel_out),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_was_clamped   (m_was_clamped),
        .m_last_of_image (m_last_of_image),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .results_owed    (results_owed)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin : watchdog
        while (cycles < RUN_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("conv2d_clamped_8bit_top_tb NOT OK");
        $finish;
    end

    initial begin : rx_side
        int unsigned hold_left;
        logic        hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = 300;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic int unsigned eff_dim(input logic [SIZE_CFG_W-1:0] v);
        if (v == 0) return 1;
        return (v > DIM_MAX) ? DIM_MAX : v;
    endfunction

    function automatic pix_t rand_pixel();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return pix_t'($urandom());
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef(input kstyle_t style);
        case (style)
            K_MILD:   return COEF_W'($urandom_range(28));
            K_SIGNED: return COEF_W'(int'($urandom_range(192)) - 64);
            K_RAW:    return COEF_W'($urandom());
            default: begin
                case ($urandom_range(4))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    2:       return 16'h0000;
                    3:       return 16'h0100;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic krow_t rand_krow(input kstyle_t style);
        return {rand_coef(style), rand_coef(style), rand_coef(style)};
    endfunction

    task automatic send_req(input logic op, input pix_t pix);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_pixel_in  <= pix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == OP_PIXEL) pixels_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic program_regs(input krow_t k0, input krow_t k1, input krow_t k2,
                                input logic pad, input logic [SIZE_CFG_W-1:0] w,
                                input logic [SIZE_CFG_W-1:0] h, input logic stray);
        logic [CFG_DATA_W-1:0] d;
        write_reg(CFG_KROW_TOP, k0);
        write_reg(CFG_KROW_MID, k1);
        write_reg(CFG_KROW_BOT, k2);
        if (stray) write_reg(CFG_UNUSED, CFG_DATA_W'({$urandom(), $urandom()}));
        d    = CFG_DATA_W'({$urandom(), $urandom()});
        d[0] = pad;
        write_reg(CFG_PADDING, d);
        d                   = CFG_DATA_W'({$urandom(), $urandom()});
        d[SIZE_CFG_W-1:0]   = w;
        write_reg(CFG_WIDTH, d);
        d                   = CFG_DATA_W'({$urandom(), $urandom()});
        d[SIZE_CFG_W-1:0]   = h;
        write_reg(CFG_HEIGHT, d);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        img_w = eff_dim(w);
        img_h = eff_dim(h);
    endtask

    task automatic run_image(input int unsigned n_pix, input logic flush,
                             input int unsigned pause_at);
        int unsigned i;
        for (i = 0; i < n_pix; i++) begin
            if (i == pause_at) wait_drained();
            if ($urandom_range(99) < 3) send_req(OP_DRAIN, rand_pixel());
            send_req(OP_PIXEL, rand_pixel());
        end
        if (flush) begin
            for (i = 0; i <= img_w; i++)
                send_req(($urandom_range(3) == 0) ? OP_PIXEL : OP_DRAIN, rand_pixel());
            if ($urandom_range(3) == 0) send_req(OP_DRAIN, rand_pixel());
        end
    endtask

    initial begin : stimulus
        kstyle_t               style;
        logic [SIZE_CFG_W-1:0] w, h;
        int unsigned           n_img, n_pix, pause_at;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset kernel, centre tap 1/256, 3x3 image with zero padding
        program_regs(KROW_TOP_RST, KROW_MID_RST, KROW_BOT_RST, 1'b1, 11'd3, 11'd3, 1'b0);
        send_req(OP_DRAIN, 8'h00);
        send_req(OP_PIXEL, 8'h00);
        send_req(OP_PIXEL, 8'hFF);
        send_req(OP_PIXEL, 8'h80);
        send_req(OP_DRAIN, 8'h11);
        send_req(OP_PIXEL, 8'h01);
        send_req(OP_PIXEL, 8'h7F);
        send_req(OP_PIXEL, 8'hFE);
        send_req(OP_PIXEL, 8'h55);
        send_req(OP_PIXEL, 8'hAA);
        send_req(OP_PIXEL, 8'h00);
        send_req(OP_PIXEL, 8'h33);
        send_req(OP_DRAIN, 8'h00);
        send_req(OP_DRAIN, 8'h00);
        send_req(OP_DRAIN, 8'h00);
        settle();

        // extreme coefficients, 2x2 image, clamps on both sides
        program_regs({16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h0100, 16'h8000},
                     {16'hFFFF, 16'h7FFF, 16'h0000}, 1'b1, 11'd2, 11'd2, 1'b0);
        send_req(OP_PIXEL, 8'hFF);
        send_req(OP_PIXEL, 8'hFF);
        send_req(OP_PIXEL, 8'h00);
        send_req(OP_PIXEL, 8'hFF);
        send_req(OP_DRAIN, 8'h00);
        send_req(OP_DRAIN, 8'h00);
        send_req(OP_DRAIN, 8'h00);
        settle();

        // valid mode without interior
        program_regs(KROW_TOP_RST, KROW_MID_RST, KROW_BOT_RST, 1'b0, 11'd0, 11'd0, 1'b0);
        send_req(OP_PIXEL, 8'hC3);
        send_req(OP_DRAIN, 8'h00);
        send_req(OP_DRAIN, 8'h00);
        settle();

        pixels_sent = 0;
        tx_idle_pct = 28;
        rx_idle_pct = 68;

        // long receiver hold-off, sender pause mid-image
        program_regs(rand_krow(K_MILD), rand_krow(K_MILD), rand_krow(K_MILD),
                     1'b1, 11'd8, 11'd6, 1'b0);
        rx_hold_req <= 1'b1;
        run_image(img_w * img_h, 1'b1, 24);
        settle();

        while (pixels_sent < 620) begin
            if (pixels_sent < 200) begin
                tx_idle_pct = 28;
                rx_idle_pct = 68;
            end else if (pixels_sent < 410) begin
                tx_idle_pct = 68;
                rx_idle_pct = 28;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            style = kstyle_t'($urandom_range(3));
            w = ($urandom_range(9) == 0) ? SIZE_CFG_W'($urandom_range(9, 24))
                                         : SIZE_CFG_W'($urandom_range(1, 8));
            h = SIZE_CFG_W'($urandom_range(1, 6));
            if ($urandom_range(19) == 0) w = '0;
            if ($urandom_range(19) == 0) h = '0;
            program_regs(rand_krow(style), rand_krow(style), rand_krow(style),
                         1'($urandom()), w, h, $urandom_range(19) == 0);
            n_img = $urandom_range(1, 3);
            repeat (n_img) begin
                n_pix    = img_w * img_h;
                pause_at = ($urandom_range(9) == 0) ? $urandom_range(n_pix) : n_pix + 1;
                if ($urandom_range(9) == 0) begin
                    run_image($urandom_range(n_pix - 1), 1'b0, pause_at);
                    break;
                end
                run_image(n_pix, 1'b1, pause_at);
            end
            settle();
        end

        // widest and tallest sizes, first pixels only
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_regs(rand_krow(K_SIGNED), rand_krow(K_SIGNED), rand_krow(K_SIGNED),
                     1'b1, 11'h7FF, 11'd1, 1'b0);
        run_image(40, 1'b0, 41);
        settle();
        program_regs(rand_krow(K_MILD), rand_krow(K_MILD), rand_krow(K_MILD),
                     1'b1, 11'd0, 11'h7FF, 1'b0);
        run_image(120, 1'b0, 121);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("conv2d_clamped_8bit_top_tb OK");
        end else begin
            $display("conv2d_clamped_8bit_top_tb NOT OK");
        end
        $finish;
    end

endmodule
